>>> src/fae_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and nudge table for the frame auto-exposure block.
// No dependencies; imported by every module of the block.
package fae_pkg;

  localparam int PIX_W    = 8;
  localparam int SUM_W    = 30;
  localparam int VAL_W    = 16;
  localparam int STEP_W   = 6;
  localparam int FACTOR_W = 7;
  localparam int PROD_W   = VAL_W + FACTOR_W;
  localparam int SCALE_SH = 6;
  localparam int BRIGHT_SH = 17;
  localparam int CFG_IDX_W = 2;
  localparam int M_DATA_W = 40;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd3;

  // Reset values of the registers
  localparam logic [VAL_W-1:0] TARGET_RST = 16'h0225;
  localparam logic [VAL_W-1:0] MIN_RST    = 16'h0100;
  localparam logic [VAL_W-1:0] MAX_RST    = 16'hffff;
  localparam logic [VAL_W-1:0] START_RST  = 16'h0100;

  // Nudge thresholds: multiples of the unit step of 20
  localparam logic [VAL_W-1:0] NUDGE_UNIT = 16'd20;
  localparam logic [VAL_W-1:0] THR_24 = 16'(35 * 20);
  localparam logic [VAL_W-1:0] THR_16 = 16'(25 * 20);
  localparam logic [VAL_W-1:0] THR_12 = 16'(15 * 20);
  localparam logic [VAL_W-1:0] THR_7  = 16'(10 * 20);
  localparam logic [VAL_W-1:0] THR_3  = 16'(3 * 20);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc;    // add the accepted pixel's square
    logic calc;   // form brightness and nudge, clear the sum
    logic mul;    // scale the exposure
    logic load;   // clamp, update exposure, fill the output register
  } fae_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } fae_stat_t;

  // Unsigned nudge magnitude in sixty-fourths for a brightness error magnitude
  function automatic logic [STEP_W-1:0] nudge_mag(input logic [VAL_W-1:0] mag);
    logic [STEP_W-1:0] n;
    if (mag > THR_24)          n = 6'd24;
    else if (mag > THR_16)     n = 6'd16;
    else if (mag > THR_12)     n = 6'd12;
    else if (mag > THR_7)      n = 6'd7;
    else if (mag > THR_3)      n = 6'd3;
    else if (mag > NUDGE_UNIT) n = 6'd1;
    else                       n = 6'd0;
    return n;
  endfunction

endpackage

>>> src/fae_ctrl.sv
`timescale 1ns / 1ps
// Controller of the frame auto-exposure block: sequences accumulation and
// the end-of-frame update. Depends on fae_pkg.
module fae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  fae_pkg::fae_stat_t stat,
  output fae_pkg::fae_cmd_t  cmd
);
  import fae_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC   = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   beat;

  assign s_tready = (state == ST_ACC);
  assign beat     = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_ACC: begin
        cmd.acc = beat;
        if (beat && s_tlast) state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register has room
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACC;
    else     state <= state_next;
  end

endmodule

>>> src/fae_dp.sv
`timescale 1ns / 1ps
// Datapath of the frame auto-exposure block: configuration registers, square
// sum, nudge, exposure scaling and output register. Depends on fae_pkg.
module fae_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fae_pkg::PIX_W-1:0]     pixel,
  input  logic                          cfg_valid,
  input  logic [fae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fae_pkg::VAL_W-1:0]     cfg_data,
  input  fae_pkg::fae_cmd_t             cmd,
  output fae_pkg::fae_stat_t            stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fae_pkg::M_DATA_W-1:0]  m_tdata
);
  import fae_pkg::*;

  logic [VAL_W-1:0]    target;
  logic [VAL_W-1:0]    min_exp;
  logic [VAL_W-1:0]    max_exp;
  logic [VAL_W-1:0]    exposure_now;
  logic [SUM_W-1:0]    square_sum;
  logic [VAL_W-1:0]    bright;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   prod;

  logic [2*PIX_W-1:0]  pix_sq;
  logic [SUM_W:0]      sum_add;
  logic [VAL_W-1:0]    bright_now;
  logic [VAL_W:0]      diff;
  logic [VAL_W-1:0]    mag;
  logic [STEP_W-1:0]   nmag;
  logic [FACTOR_W-1:0] factor;
  logic [VAL_W:0]      scaled;
  logic [VAL_W-1:0]    expo_clamped;

  assign stat.out_free = !m_tvalid || m_tready;

  // Accumulate with saturation at the top of the sum range
  assign pix_sq  = pixel * pixel;
  assign sum_add = {1'b0, square_sum} + (SUM_W+1)'(pix_sq);

  // Brightness, error and signed nudge
  assign bright_now = VAL_W'(square_sum >> BRIGHT_SH);
  assign diff       = {1'b0, target} - {1'b0, bright_now};
  assign mag        = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  assign nmag       = nudge_mag(mag);

  // Scale factor 64 + nudge, always in 40..88
  assign factor = FACTOR_W'(7'd64 + {step[STEP_W-1], step});

  // Clamp: the lower bound is tested first, then the upper bound
  assign scaled = prod[PROD_W-1:SCALE_SH];
  always_comb begin
    if (scaled < {1'b0, min_exp})      expo_clamped = min_exp;
    else if (scaled > {1'b0, max_exp}) expo_clamped = max_exp;
    else                               expo_clamped = scaled[VAL_W-1:0];
  end

  // Configuration registers and exposure state
  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= TARGET_RST;
      min_exp      <= MIN_RST;
      max_exp      <= MAX_RST;
      exposure_now <= START_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TARGET: target       <= cfg_data;
          REG_MIN:    min_exp      <= cfg_data;
          REG_MAX:    max_exp      <= cfg_data;
          REG_START:  exposure_now <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) exposure_now <= expo_clamped;
    end
  end

  // Square sum: add on each pixel beat, clear once the frame is evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
    end else if (cmd.calc) begin
      square_sum <= '0;
    end else if (cmd.acc) begin
      square_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end
  end

  // Pipeline registers of the update
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      bright <= bright_now;
      step   <= diff[VAL_W] ? STEP_W'(-nmag) : nmag;
    end
    if (cmd.mul) prod <= exposure_now * factor;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) m_tdata <= {2'b00, step, bright, expo_clamped};
  end

endmodule

>>> src/frame_auto_exposure.sv
`timescale 1ns / 1ps
// Frame auto-exposure: takes one pixel beat per cycle while s_tready is high and
// accumulates its square. A beat with tlast starts the update (error and nudge,
// multiply, clamp); m_tvalid rises at the clamp step, later if the output stalls.
// Input is blocked during the update; the output register lets a frame start while
// a result waits. Synchronous reset restores all but the update and data registers.
module frame_auto_exposure (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel
  input  logic                          s_tlast,   // last_pixel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] new_exposure, [31:16] brightness, [37:32] step_applied, [39:38] zero
  output logic [fae_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fae_pkg::VAL_W-1:0]     cfg_data
);
  import fae_pkg::*;

  fae_cmd_t  cmd;
  fae_stat_t stat;

  // Configuration is taken at any time
  assign cfg_ready = 1'b1;

  fae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fae_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .pixel     (s_tdata[PIX_W-1:0]),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> src/fae_checker.sv
`timescale 1ns / 1ps
// Port-level checks for frame_auto_exposure, bound to the top level.
// Depends on fae_pkg for widths.
module fae_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [fae_pkg::M_DATA_W-1:0] m_tdata
);
  import fae_pkg::*;

  logic last_beat;
  assign last_beat = s_tvalid && s_tready && s_tlast;

  // A stalled result holds its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input stays blocked through the calc, multiply and load steps after a frame end
  a_update_block: assert property (@(posedge clk) disable iff (rst)
    last_beat |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("pixel accepted during frame update");

  // A result appearing on an idle output follows a frame end after the calc, multiply and load steps
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(last_beat, 4))
    else $error("result without matching frame end");

endmodule

bind frame_auto_exposure fae_checker u_fae_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/tb_frame_auto_exposure.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_auto_exposure: pixel frames in, exposure updates out.
// Depends on fae_pkg and the frame_auto_exposure RTL; predicts untyped updates itself.
module tb_frame_auto_exposure;
  import fae_pkg::*;

  localparam int SUM_CAP       = 32'h3fff_ffff;
  localparam int PHASES        = 24;
  localparam int PHASE_PIXELS  = 42;
  localparam int PRESSURE_PH   = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  // Expected update, packed like m_tdata from bit 0 up
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [VAL_W-1:0]  bright;
    logic [VAL_W-1:0]  expo;
  } exposure_result_t;

  // Directed row: either a register setting or one pixel beat
  typedef struct {
    bit               is_cfg;
    logic [VAL_W-1:0] tgt;
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] st;
    logic [PIX_W-1:0] px;
    bit               last;
    bit               typed;
    exposure_result_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;    // [7:0] pixel
  logic                 s_tlast = 1'b0;  // last_pixel
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [15:0] new_exposure, [31:16] brightness, [37:32] step_applied, [39:38] zero
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  // Shadow of the block's registers and state
  logic [VAL_W-1:0] tgt_reg   = TARGET_RST;
  logic [VAL_W-1:0] min_reg   = MIN_RST;
  logic [VAL_W-1:0] max_reg   = MAX_RST;
  logic [SUM_W-1:0] acc_sum   = '0;
  logic [VAL_W-1:0] cur_expo  = START_RST;

  exposure_result_t pending_updates[$];
  stim_row_t        directed_rows[$];
  int               mismatches = 0;
  int               src_idle_pct = 0;
  int               sink_idle_pct = 0;
  int               hold_req = 0;
  int               hold_seen = 0;
  int               hold_left = 0;

  localparam logic [VAL_W-1:0] NUDGE_BOUNDS [12] =
    '{16'd20, 16'd21, 16'd60, 16'd61, 16'd200, 16'd201,
      16'd300, 16'd301, 16'd500, 16'd501, 16'd700, 16'd701};

  frame_auto_exposure dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow state by one pixel; produce the update on a frame end
  function automatic void predict_pixel(input logic [PIX_W-1:0] px, input logic last,
                                        output bit has_res, output exposure_result_t res);
    logic [31:0] sum;
    logic [31:0] bright;
    logic [31:0] scaled;
    int          diff;
    int          mag;
    int          nudge;
    sum = 32'(acc_sum) + 32'(px) * 32'(px);
    if (sum > SUM_CAP) sum = SUM_CAP;
    acc_sum = sum[SUM_W-1:0];
    has_res = 1'b0;
    res = '0;
    if (!last) return;

    bright = 32'(acc_sum) >> 17;
    if (bright > 32'hffff) bright = 32'hffff;
    diff = int'(tgt_reg) - int'(bright);
    mag = (diff < 0) ? -diff : diff;
    if (mag > 700)      nudge = 24;
    else if (mag > 500) nudge = 16;
    else if (mag > 300) nudge = 12;
    else if (mag > 200) nudge = 7;
    else if (mag > 60)  nudge = 3;
    else if (mag > 20)  nudge = 1;
    else                nudge = 0;
    if (diff < 0) nudge = -nudge;

    // Scale, then clamp: test the minimum first, then the maximum
    scaled = (32'(cur_expo) * 32'(64 + nudge)) >> 6;
    if (scaled < 32'(min_reg))      scaled = 32'(min_reg);
    else if (scaled > 32'(max_reg)) scaled = 32'(max_reg);
    cur_expo = scaled[VAL_W-1:0];
    acc_sum = '0;
    has_res = 1'b1;
    res.expo = cur_expo;
    res.bright = bright[VAL_W-1:0];
    res.step = STEP_W'(nudge);
  endfunction

  // Offer one pixel beat, possibly after idle cycles; record it once accepted
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last,
                            input bit typed, input exposure_result_t want);
    bit               has_res;
    exposure_result_t res;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_pixel(px, last, has_res, res);
    if (has_res) pending_updates.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TARGET: tgt_reg = val;
      REG_MIN:    min_reg = val;
      REG_MAX:    max_reg = val;
      REG_START:  cur_expo = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [VAL_W-1:0] tgt, input logic [VAL_W-1:0] mn,
                            input logic [VAL_W-1:0] mx, input logic [VAL_W-1:0] st);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_START, st);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering pixels, wait for every pending update, let the pipeline settle
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: check each update beat, then pick the next ready level
  always @(posedge clk) begin : result_sink
    exposure_result_t got;
    exposure_result_t exp_res;
    got = m_tdata[37:0];
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected update: expo %0d bright %0d step %0d",
                     got.expo, got.bright, $signed(got.step));
        end else begin
          exp_res = pending_updates.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("update mismatch: expected expo %0d bright %0d step %0d,",
                       exp_res.expo, exp_res.bright, $signed(exp_res.step),
                       " got expo %0d bright %0d step %0d",
                       got.expo, got.bright, $signed(got.step));
          end
        end
      end
      // Hold off for a long stretch when asked, else stall at random
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run after too many cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("frame_auto_exposure regression: fail");
    $finish;
  end

  initial begin : stimulus
    int               len;
    int               sent;
    logic [VAL_W-1:0] tgt;
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] mx;

    // Reset values first, then min above max, extremes and a threshold edge
    directed_rows = '{
      '{0, 0, 0, 0, 0, 8'd0,   1, 1, '{6'd16, 16'd0, 16'd320}},
      '{0, 0, 0, 0, 0, 8'd255, 1, 1, '{6'd16, 16'd0, 16'd400}},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd0,   1, 0, '0},
      '{0, 0, 0, 0, 0, 8'd128, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd1,   0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd254, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd127, 1, 0, '0},
      '{1, 16'd0, 16'd5000, 16'd1000, 16'd3000, 8'd0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd0,   1, 1, '{6'd0, 16'd0, 16'd5000}},
      '{1, 16'hffff, 16'd0, 16'hffff, 16'hffff, 8'd0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd0,   1, 1, '{6'd24, 16'd0, 16'hffff}},
      '{1, 16'd0, 16'd0, 16'hffff, 16'd0, 8'd0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 1, 1, '{6'd0, 16'd0, 16'd0}},
      '{1, 16'd0, 16'd0, 16'hffff, 16'd64, 8'd0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd255, 1, 0, '0},
      '{1, 16'd300, 16'd0, 16'hffff, 16'd1000, 8'd0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 8'd0,   1, 0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 19;
    sink_idle_pct = 48;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        finish_phase();
        set_config(directed_rows[i].tgt, directed_rows[i].mn,
                   directed_rows[i].mx, directed_rows[i].st);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with fresh register values and whole frames
    for (int p = 0; p < PHASES; p++) begin
      finish_phase();
      if (p < PHASES / 3) begin
        src_idle_pct = 19;
        sink_idle_pct = 48;
      end else if (p < 2 * PHASES / 3) begin
        src_idle_pct = 48;
        sink_idle_pct = 19;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case ($urandom_range(4))
        0:       tgt = NUDGE_BOUNDS[$urandom_range(11)];
        1:       tgt = VAL_W'($urandom_range(30));
        2:       tgt = VAL_W'($urandom_range(1000));
        3:       tgt = VAL_W'($urandom_range(65535));
        default: tgt = $urandom_range(1) ? 16'hffff : 16'd0;
      endcase
      case ($urandom_range(3))
        0:       mn = 16'd0;
        1:       mn = VAL_W'($urandom_range(2000));
        2:       mn = VAL_W'($urandom_range(65535));
        default: mn = 16'hffff;
      endcase
      case ($urandom_range(3))
        0:       mx = 16'hffff;
        1:       mx = VAL_W'($urandom_range(65535, 1000));
        2:       mx = VAL_W'($urandom_range(65535));
        default: mx = 16'd0;
      endcase
      set_config(tgt, mn, mx, VAL_W'($urandom_range(65535)));
      if (p == PRESSURE_PH) hold_req++;

      sent = 0;
      while (sent < PHASE_PIXELS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          send_pixel(PIX_W'($urandom_range(255)), i == len - 1, 1'b0, '0);
        sent += len;
      end
    end

    finish_phase();
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("frame_auto_exposure regression: pass");
    end else begin
      $display("frame_auto_exposure regression: fail");
    end
    $finish;
  end

endmodule
